[design/lkm_pkg.sv]
package lkm_pkg;

    typedef enum logic [2:0] {
        KIND_WR_ADDR  = 3'd0,
        KIND_WR_DATA  = 3'd1,
        KIND_RD_ADDR  = 3'd2,
        KIND_RD_ACK   = 3'd3,
        KIND_RD_NACK  = 3'd4,
        KIND_BUS_MISC = 3'd5,
        KIND_TICK     = 3'd6,
        KIND_FETCH    = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] key_code;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       nack;
        logic [7:0] event_mask;
    } result_t;

    // Control from the sequencer to the byte store.
    typedef struct packed {
        logic rd;
        logic wr;
        logic clear;
    } store_cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONTRAST_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_ROW_LIMIT        = 2'd1;
    localparam logic [1:0] CFG_COLUMN_LIMIT     = 2'd2;
    localparam logic [1:0] CFG_CONTRAST_DEFAULT = 2'd3;

    localparam logic [5:0] CONTRAST_LIMIT_RST   = 6'd63;
    localparam logic [1:0] ROW_LIMIT_RST        = 2'd1;
    localparam logic [5:0] COLUMN_LIMIT_RST     = 6'd15;
    localparam logic [5:0] CONTRAST_DEFAULT_RST = 6'd40;

    // Fixed map addresses below the RAM windows.
    localparam logic [7:0] ADDR_STATUS   = 8'd0;
    localparam logic [7:0] ADDR_LAST_KEY = 8'd1;
    localparam logic [7:0] ADDR_POWER    = 8'd2;
    localparam logic [7:0] ADDR_CONTRAST = 8'd3;
    localparam logic [7:0] ADDR_CURSOR   = 8'd4;
    localparam logic [7:0] ADDR_ROW      = 8'd5;
    localparam logic [7:0] ADDR_COLUMN   = 8'd6;
    localparam int         MAP_FIXED     = 7;

    localparam logic [7:0] GLYPH_FILL  = 8'hE0;
    localparam logic [7:0] PIXEL_MAX   = 8'h1F;
    localparam logic [7:0] CODE_MAX    = 8'h03;
    localparam logic [7:0] NO_KEY      = 8'hFF;
    localparam logic [7:0] OVERFLOW_RD = 8'hFF;
    localparam logic [7:0] LINE_SPLIT  = 8'd40;
    localparam logic [7:0] TICK_WRAP   = 8'd128;
    localparam logic [1:0] POWER_RST   = 2'd1;

    localparam logic [7:0] EV_TIMER = 8'h01;
    localparam logic [7:0] EV_POWER = 8'h02;
    localparam logic [7:0] EV_CSET  = 8'h04;
    localparam logic [7:0] EV_CMOVE = 8'h08;
    localparam logic [7:0] EV_LINE0 = 8'h10;
    localparam logic [7:0] EV_LINE1 = 8'h20;
    localparam logic [7:0] EV_GLYPH = 8'h40;
    localparam logic [7:0] EV_ICON  = 8'h80;

endpackage

[design/lcd_keypad_i2c_register_map.sv]
// Register map of an I2C-slave bridge for a character LCD and keypad.
//
// Requests arrive on the command channel: drive item and raise start; the
// request is taken on a clock edge where start is high and busy is low.
// Every request yields exactly one result, shown on result for a single
// cycle with done high. The receiver cannot hold results off, and none is
// needed: only one request is in flight at a time.
//
// busy is high only while a request is in the EXEC state, so a new request
// may be accepted in the very cycle done is shown; the block takes no new
// request before it is through with the last. This pacing is set by the
// read-modify-write of the byte store: the entry at the map pointer is read
// when the request is accepted and updated in the EXEC state.
//
// Configuration is written on the cfg channel (cfg_ready is always high); the
// user must write it only while no request is in flight: the block does not
// enforce it. Reset at once restores all state but the held request and result;
// the display, glyph and icon RAMs need no clearing pass, and power-off clears them.
module lcd_keypad_i2c_register_map #(
    parameter int DISPLAY_BYTES = 80,
    parameter int GLYPH_BYTES = 64,
    parameter int ICON_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lkm_pkg::item_t    item,
    output logic              done,
    output lkm_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data
);

    localparam int STORE_DEPTH = DISPLAY_BYTES + GLYPH_BYTES + ICON_BYTES;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [8:0] GLYPH_BASE_W = 9'(lkm_pkg::MAP_FIXED + DISPLAY_BYTES);
    localparam logic [8:0] ICON_BASE_W  = 9'(lkm_pkg::MAP_FIXED + DISPLAY_BYTES + GLYPH_BYTES);
    localparam logic [8:0] MAP_END_W    = 9'(lkm_pkg::MAP_FIXED + STORE_DEPTH);
    localparam logic [8:0] FIXED_W      = 9'(lkm_pkg::MAP_FIXED);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    lkm_pkg::item_t      item_reg;
    lkm_pkg::result_t    result_reg, result_next;
    logic                done_reg;

    logic [5:0] contrast_limit_reg, row_limit_pad, column_limit_reg, contrast_default_reg;
    logic [1:0] row_limit_reg;

    logic [7:0] pointer_reg, pointer_next;
    logic       start_pending_reg, start_pending_next;
    logic       busy_flag_reg, busy_flag_next;
    logic [7:0] last_key_reg, last_key_next;
    logic [1:0] power_reg, power_next;
    logic [5:0] contrast_reg, contrast_next;
    logic [1:0] cursor_mode_reg, cursor_mode_next;
    logic [1:0] row_reg, row_next;
    logic [5:0] column_reg, column_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] tick_reg, tick_next;

    lkm_pkg::store_cmd_t store_cmd;
    logic [7:0]          store_rd_data;
    logic [7:0]          ptr_off;
    logic [8:0]          ptr_w;
    logic                in_map, is_display, is_glyph, is_icon;
    logic [7:0]          wdata;
    logic [7:0]          ev;
    logic [7:0]          rd_value;

    assign row_limit_pad = {4'b0, row_limit_reg};

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign ptr_w      = {1'b0, pointer_reg};
    assign ptr_off    = pointer_reg - 8'(lkm_pkg::MAP_FIXED);
    assign in_map     = ptr_w < MAP_END_W;
    assign is_display = (ptr_w >= FIXED_W) && (ptr_w < GLYPH_BASE_W);
    assign is_glyph   = (ptr_w >= GLYPH_BASE_W) && (ptr_w < ICON_BASE_W);
    assign is_icon    = (ptr_w >= ICON_BASE_W) && in_map;
    assign wdata      = item_reg.data;

    lkm_store #(
        .DEPTH    (STORE_DEPTH),
        .GLYPH_LO (DISPLAY_BYTES),
        .GLYPH_HI (DISPLAY_BYTES + GLYPH_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .rd_addr (ptr_off[AW-1:0]),
        .wr_addr (ptr_off[AW-1:0]),
        .wr_data (wdata),
        .rd_data (store_rd_data)
    );

    always_comb
    begin
        unique case (pointer_reg)
            lkm_pkg::ADDR_STATUS:   rd_value = {7'b0, busy_flag_reg};
            lkm_pkg::ADDR_LAST_KEY: rd_value = last_key_reg;
            lkm_pkg::ADDR_POWER:    rd_value = {6'b0, power_reg};
            lkm_pkg::ADDR_CONTRAST: rd_value = {2'b0, contrast_reg};
            lkm_pkg::ADDR_CURSOR:   rd_value = {6'b0, cursor_mode_reg};
            lkm_pkg::ADDR_ROW:      rd_value = {6'b0, row_reg};
            lkm_pkg::ADDR_COLUMN:   rd_value = {2'b0, column_reg};
            default:                rd_value = store_rd_data;
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        pointer_next       = pointer_reg;
        start_pending_next = start_pending_reg;
        busy_flag_next     = busy_flag_reg;
        last_key_next      = last_key_reg;
        power_next         = power_reg;
        contrast_next      = contrast_reg;
        cursor_mode_next   = cursor_mode_reg;
        row_next           = row_reg;
        column_next        = column_reg;
        pending_next       = pending_reg;
        tick_next          = tick_reg;
        result_next        = '0;
        ev                 = '0;
        store_cmd          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Fetch the store entry under the pointer for the update cycle.
                    store_cmd.rd = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (item_reg.kind) inside
                    lkm_pkg::KIND_WR_ADDR:
                    begin
                        start_pending_next = 1'b1;
                    end
                    lkm_pkg::KIND_WR_DATA:
                    begin
                        start_pending_next = 1'b0;
                        if (start_pending_reg)
                        begin
                            if ({1'b0, wdata} < MAP_END_W)
                            begin
                                pointer_next = wdata;
                            end
                            else
                            begin
                                result_next.nack = 1'b1;
                            end
                        end
                        else if (!in_map)
                        begin
                            result_next.nack = 1'b1;
                        end
                        else
                        begin
                            if (pointer_reg == lkm_pkg::ADDR_LAST_KEY)
                            begin
                                last_key_next = wdata;
                            end
                            else if (pointer_reg == lkm_pkg::ADDR_POWER)
                            begin
                                if (wdata > lkm_pkg::CODE_MAX)
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if ({6'b0, power_reg} != wdata)
                                begin
                                    if (!wdata[0])
                                    begin
                                        power_next       = 2'b00;
                                        contrast_next    = contrast_default_reg;
                                        cursor_mode_next = 2'b00;
                                        row_next         = 2'b00;
                                        column_next      = 6'b0;
                                        store_cmd.clear  = 1'b1;
                                    end
                                    else
                                    begin
                                        power_next = wdata[1:0];
                                    end
                                    ev = lkm_pkg::EV_POWER;
                                end
                            end
                            else if (pointer_reg == lkm_pkg::ADDR_CONTRAST)
                            begin
                                if (wdata > {2'b0, contrast_limit_reg})
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if ({2'b0, contrast_reg} != wdata)
                                begin
                                    contrast_next = wdata[5:0];
                                    ev            = lkm_pkg::EV_POWER;
                                end
                            end
                            else if (pointer_reg == lkm_pkg::ADDR_CURSOR)
                            begin
                                if (wdata > lkm_pkg::CODE_MAX)
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if ({6'b0, cursor_mode_reg} != wdata)
                                begin
                                    cursor_mode_next = wdata[1:0];
                                    ev               = lkm_pkg::EV_CSET;
                                end
                            end
                            else if (pointer_reg == lkm_pkg::ADDR_ROW)
                            begin
                                if (wdata > {2'b0, row_limit_pad})
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if ({6'b0, row_reg} != wdata)
                                begin
                                    row_next = wdata[1:0];
                                    ev       = lkm_pkg::EV_CMOVE;
                                end
                            end
                            else if (pointer_reg == lkm_pkg::ADDR_COLUMN)
                            begin
                                if (wdata > {2'b0, column_limit_reg})
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if ({2'b0, column_reg} != wdata)
                                begin
                                    column_next = wdata[5:0];
                                    ev          = lkm_pkg::EV_CMOVE;
                                end
                            end
                            else if (is_display)
                            begin
                                if (store_rd_data != wdata)
                                begin
                                    store_cmd.wr = 1'b1;
                                    ev = (ptr_off < lkm_pkg::LINE_SPLIT) ? lkm_pkg::EV_LINE0
                                                                         : lkm_pkg::EV_LINE1;
                                end
                            end
                            else if (is_glyph || is_icon)
                            begin
                                if (wdata > lkm_pkg::PIXEL_MAX)
                                begin
                                    result_next.nack = 1'b1;
                                end
                                else if (store_rd_data != wdata)
                                begin
                                    store_cmd.wr = 1'b1;
                                    ev = is_glyph ? lkm_pkg::EV_GLYPH : lkm_pkg::EV_ICON;
                                end
                            end
                            // The status byte is read only: the write is dropped.
                            if (!result_next.nack)
                            begin
                                pointer_next = pointer_reg + 8'd1;
                            end
                        end
                    end
                    lkm_pkg::KIND_RD_ADDR, lkm_pkg::KIND_RD_ACK:
                    begin
                        result_next.read_valid = 1'b1;
                        if (!in_map)
                        begin
                            result_next.nack      = 1'b1;
                            result_next.read_data = lkm_pkg::OVERFLOW_RD;
                        end
                        else
                        begin
                            result_next.read_data = rd_value;
                            if (pointer_reg == lkm_pkg::ADDR_LAST_KEY)
                            begin
                                last_key_next = lkm_pkg::NO_KEY;
                            end
                            pointer_next = pointer_reg + 8'd1;
                        end
                    end
                    lkm_pkg::KIND_RD_NACK:
                    begin
                        state_next = ST_IDLE;
                    end
                    lkm_pkg::KIND_BUS_MISC:
                    begin
                        start_pending_next = 1'b0;
                    end
                    lkm_pkg::KIND_TICK:
                    begin
                        tick_next = (tick_reg < lkm_pkg::TICK_WRAP) ? tick_reg + 8'd1 : 8'd0;
                        if (!tick_next[0])
                        begin
                            ev = lkm_pkg::EV_TIMER;
                        end
                        if (item_reg.key_code != lkm_pkg::NO_KEY)
                        begin
                            last_key_next = item_reg.key_code;
                        end
                    end
                    lkm_pkg::KIND_FETCH:
                    begin
                        result_next.event_mask = pending_reg;
                        if (pending_reg == 8'h00)
                        begin
                            busy_flag_next = 1'b0;
                        end
                        else
                        begin
                            pending_next = 8'h00;
                            if ((pending_reg & lkm_pkg::EV_POWER) != 8'h00)
                            begin
                                power_next[0] = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase

                if (ev != 8'h00)
                begin
                    busy_flag_next = 1'b1;
                    pending_next   = pending_reg | ev;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            done_reg          <= 1'b0;
            pointer_reg       <= 8'h00;
            start_pending_reg <= 1'b0;
            busy_flag_reg     <= 1'b0;
            last_key_reg      <= lkm_pkg::NO_KEY;
            power_reg         <= lkm_pkg::POWER_RST;
            contrast_reg      <= lkm_pkg::CONTRAST_DEFAULT_RST;
            cursor_mode_reg   <= 2'b00;
            row_reg           <= 2'b00;
            column_reg        <= 6'b0;
            pending_reg       <= 8'h00;
            tick_reg          <= 8'h00;
        end
        else
        begin
            state_reg         <= state_next;
            done_reg          <= (state_reg == ST_EXEC);
            pointer_reg       <= pointer_next;
            start_pending_reg <= start_pending_next;
            busy_flag_reg     <= busy_flag_next;
            last_key_reg      <= last_key_next;
            power_reg         <= power_next;
            contrast_reg      <= contrast_next;
            cursor_mode_reg   <= cursor_mode_next;
            row_reg           <= row_next;
            column_reg        <= column_next;
            pending_reg       <= pending_next;
            tick_reg          <= tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_limit_reg   <= lkm_pkg::CONTRAST_LIMIT_RST;
            row_limit_reg        <= lkm_pkg::ROW_LIMIT_RST;
            column_limit_reg     <= lkm_pkg::COLUMN_LIMIT_RST;
            contrast_default_reg <= lkm_pkg::CONTRAST_DEFAULT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lkm_pkg::CFG_CONTRAST_LIMIT:   contrast_limit_reg   <= cfg_data;
                lkm_pkg::CFG_ROW_LIMIT:        row_limit_reg        <= cfg_data[1:0];
                lkm_pkg::CFG_COLUMN_LIMIT:     column_limit_reg     <= cfg_data;
                lkm_pkg::CFG_CONTRAST_DEFAULT: contrast_default_reg <= cfg_data;
                default:                       contrast_limit_reg   <= contrast_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[design/lkm_store.sv]
module lkm_store #(
    parameter int DEPTH = 160,
    parameter int GLYPH_LO = 80,
    parameter int GLYPH_HI = 144,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lkm_pkg::store_cmd_t  cmd,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [7:0]           wr_data,
    output logic [7:0]           rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       mem_q_reg;
    logic             valid_q_reg;
    logic [AW-1:0]    addr_q_reg;
    logic             glyph_q;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            mem_q_reg   <= mem[rd_addr];
            valid_q_reg <= valid_reg[rd_addr];
            addr_q_reg  <= rd_addr;
        end
    end

    // An entry never written since reset or the last power-off reads as its
    // reset value, so no clearing pass is needed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign glyph_q = ({1'b0, addr_q_reg} >= (AW+1)'(GLYPH_LO))
                  && ({1'b0, addr_q_reg} <  (AW+1)'(GLYPH_HI));

    assign rd_data = valid_q_reg ? mem_q_reg : (glyph_q ? lkm_pkg::GLYPH_FILL : 8'h00);

endmodule

[test/lkm_map_checker.sv]
module lkm_map_checker #(
    parameter int DISPLAY_BYTES = 80,
    parameter int GLYPH_BYTES = 64,
    parameter int ICON_BYTES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  lkm_pkg::item_t   item,
    input  logic             done,
    input  lkm_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [5:0]       cfg_data,
    output int               mismatches,
    output int               replies_owed
);

    localparam int GLYPH_BASE = lkm_pkg::MAP_FIXED + DISPLAY_BYTES;
    localparam int ICON_BASE = GLYPH_BASE + GLYPH_BYTES;
    localparam int MAP_END = ICON_BASE + ICON_BYTES;

    logic [5:0] contrast_cap;
    logic [1:0] row_cap;
    logic [5:0] column_cap;
    logic [5:0] contrast_preset;

    logic       status_busy;
    logic [7:0] key_latch;
    logic [1:0] power_state;
    logic [7:0] contrast_level;
    logic [1:0] cursor_shape;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] display_ram [DISPLAY_BYTES];
    logic [7:0] glyph_ram [GLYPH_BYTES];
    logic [4:0] icon_ram [ICON_BYTES];
    logic [7:0] pointer;
    logic       pointer_byte_due;
    logic [7:0] pending_events;
    logic [7:0] tick_phase;

    lkm_pkg::result_t owed_results[$];
    lkm_pkg::result_t oldest;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void blank_panel();
        cursor_shape = '0;
        cursor_row = '0;
        cursor_col = '0;
        for (int i = 0; i < DISPLAY_BYTES; i++)
        begin
            display_ram[i] = '0;
        end
        for (int i = 0; i < GLYPH_BYTES; i++)
        begin
            glyph_ram[i] = lkm_pkg::GLYPH_FILL;
        end
        for (int i = 0; i < ICON_BYTES; i++)
        begin
            icon_ram[i] = '0;
        end
    endfunction

    function automatic void restore_reset_state();
        contrast_cap = lkm_pkg::CONTRAST_LIMIT_RST;
        row_cap = lkm_pkg::ROW_LIMIT_RST;
        column_cap = lkm_pkg::COLUMN_LIMIT_RST;
        contrast_preset = lkm_pkg::CONTRAST_DEFAULT_RST;
        status_busy = 1'b0;
        key_latch = lkm_pkg::NO_KEY;
        power_state = lkm_pkg::POWER_RST;
        contrast_level = {2'd0, contrast_preset};
        blank_panel();
        pointer = '0;
        pointer_byte_due = 1'b0;
        pending_events = '0;
        tick_phase = '0;
    endfunction

    function automatic void raise_events(input logic [7:0] bits);
        status_busy = 1'b1;
        pending_events = pending_events | bits;
    endfunction

    // Returns 1 when the byte is refused; a refused byte leaves the pointer alone.
    function automatic logic write_through_pointer(input logic [7:0] v);
        int p;
        p = int'(pointer);
        if (p >= MAP_END)
            return 1'b1;
        if (p == int'(lkm_pkg::ADDR_LAST_KEY))
        begin
            key_latch = v;
        end
        else if (p == int'(lkm_pkg::ADDR_POWER))
        begin
            if (v > lkm_pkg::CODE_MAX)
                return 1'b1;
            if (v != {6'd0, power_state})
            begin
                // Switching off restores the panel to its reset contents.
                if (!v[0])
                begin
                    power_state = '0;
                    contrast_level = {2'd0, contrast_preset};
                    blank_panel();
                end
                else
                begin
                    power_state = v[1:0];
                end
                raise_events(lkm_pkg::EV_POWER);
            end
        end
        else if (p == int'(lkm_pkg::ADDR_CONTRAST))
        begin
            if (v > {2'd0, contrast_cap})
                return 1'b1;
            if (v != contrast_level)
            begin
                contrast_level = v;
                raise_events(lkm_pkg::EV_POWER);
            end
        end
        else if (p == int'(lkm_pkg::ADDR_CURSOR))
        begin
            if (v > lkm_pkg::CODE_MAX)
                return 1'b1;
            if (v != {6'd0, cursor_shape})
            begin
                cursor_shape = v[1:0];
                raise_events(lkm_pkg::EV_CSET);
            end
        end
        else if (p == int'(lkm_pkg::ADDR_ROW))
        begin
            if (v > {6'd0, row_cap})
                return 1'b1;
            if (v != cursor_row)
            begin
                cursor_row = v;
                raise_events(lkm_pkg::EV_CMOVE);
            end
        end
        else if (p == int'(lkm_pkg::ADDR_COLUMN))
        begin
            if (v > {2'd0, column_cap})
                return 1'b1;
            if (v != cursor_col)
            begin
                cursor_col = v;
                raise_events(lkm_pkg::EV_CMOVE);
            end
        end
        else if (p >= lkm_pkg::MAP_FIXED && p < GLYPH_BASE)
        begin
            if (display_ram[p - lkm_pkg::MAP_FIXED] != v)
            begin
                display_ram[p - lkm_pkg::MAP_FIXED] = v;
                raise_events((p - lkm_pkg::MAP_FIXED) < int'(lkm_pkg::LINE_SPLIT)
                             ? lkm_pkg::EV_LINE0 : lkm_pkg::EV_LINE1);
            end
        end
        else if (p >= GLYPH_BASE && p < ICON_BASE)
        begin
            if (v > lkm_pkg::PIXEL_MAX)
                return 1'b1;
            if (glyph_ram[p - GLYPH_BASE] != v)
            begin
                glyph_ram[p - GLYPH_BASE] = v;
                raise_events(lkm_pkg::EV_GLYPH);
            end
        end
        else if (p >= ICON_BASE)
        begin
            if (v > lkm_pkg::PIXEL_MAX)
                return 1'b1;
            if ({3'd0, icon_ram[p - ICON_BASE]} != v)
            begin
                icon_ram[p - ICON_BASE] = v[4:0];
                raise_events(lkm_pkg::EV_ICON);
            end
        end
        pointer = pointer + 8'd1;
        return 1'b0;
    endfunction

    function automatic logic read_through_pointer(output logic [7:0] v);
        int p;
        p = int'(pointer);
        v = lkm_pkg::OVERFLOW_RD;
        if (p >= MAP_END)
            return 1'b1;
        if (p == int'(lkm_pkg::ADDR_STATUS))
        begin
            v = {7'd0, status_busy};
        end
        else if (p == int'(lkm_pkg::ADDR_LAST_KEY))
        begin
            v = key_latch;
            key_latch = lkm_pkg::NO_KEY;
        end
        else if (p == int'(lkm_pkg::ADDR_POWER))
            v = {6'd0, power_state};
        else if (p == int'(lkm_pkg::ADDR_CONTRAST))
            v = contrast_level;
        else if (p == int'(lkm_pkg::ADDR_CURSOR))
            v = {6'd0, cursor_shape};
        else if (p == int'(lkm_pkg::ADDR_ROW))
            v = cursor_row;
        else if (p == int'(lkm_pkg::ADDR_COLUMN))
            v = cursor_col;
        else if (p < GLYPH_BASE)
            v = display_ram[p - lkm_pkg::MAP_FIXED];
        else if (p < ICON_BASE)
            v = glyph_ram[p - GLYPH_BASE];
        else
            v = {3'd0, icon_ram[p - ICON_BASE]};
        pointer = pointer + 8'd1;
        return 1'b0;
    endfunction

    function automatic lkm_pkg::result_t map_access(input lkm_pkg::item_t req);
        lkm_pkg::result_t r;
        logic [7:0] byte_out;
        r = '0;
        case (req.kind) inside
            lkm_pkg::KIND_WR_ADDR:
            begin
                pointer_byte_due = 1'b1;
            end
            lkm_pkg::KIND_WR_DATA:
            begin
                if (pointer_byte_due)
                begin
                    if (int'(req.data) < MAP_END)
                        pointer = req.data;
                    else
                        r.nack = 1'b1;
                end
                else
                begin
                    r.nack = write_through_pointer(req.data);
                end
                pointer_byte_due = 1'b0;
            end
            lkm_pkg::KIND_RD_ADDR, lkm_pkg::KIND_RD_ACK:
            begin
                r.nack = read_through_pointer(byte_out);
                r.read_data = byte_out;
                r.read_valid = 1'b1;
            end
            lkm_pkg::KIND_BUS_MISC:
            begin
                pointer_byte_due = 1'b0;
            end
            lkm_pkg::KIND_TICK:
            begin
                if (tick_phase < lkm_pkg::TICK_WRAP)
                    tick_phase = tick_phase + 8'd1;
                else
                    tick_phase = '0;
                if (!tick_phase[0])
                    raise_events(lkm_pkg::EV_TIMER);
                if (req.key_code != lkm_pkg::NO_KEY)
                    key_latch = req.key_code;
            end
            lkm_pkg::KIND_FETCH:
            begin
                r.event_mask = pending_events;
                if (pending_events == '0)
                begin
                    status_busy = 1'b0;
                end
                else
                begin
                    pending_events = '0;
                    if ((r.event_mask & lkm_pkg::EV_POWER) != '0)
                        power_state[0] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_reset_state();
            owed_results.delete();
            replies_owed <= 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no request outstanding", result));
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    if (result.read_data !== oldest.read_data)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  result.read_data, oldest.read_data));
                    if (result.read_valid !== oldest.read_valid)
                        report_mismatch($sformatf("read_valid %b, expected %b",
                                                  result.read_valid, oldest.read_valid));
                    if (result.nack !== oldest.nack)
                        report_mismatch($sformatf("nack %b, expected %b",
                                                  result.nack, oldest.nack));
                    if (result.event_mask !== oldest.event_mask)
                        report_mismatch($sformatf("event_mask %h, expected %h",
                                                  result.event_mask, oldest.event_mask));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lkm_pkg::CFG_CONTRAST_LIMIT:   contrast_cap = cfg_data;
                    lkm_pkg::CFG_ROW_LIMIT:        row_cap = cfg_data[1:0];
                    lkm_pkg::CFG_COLUMN_LIMIT:     column_cap = cfg_data;
                    lkm_pkg::CFG_CONTRAST_DEFAULT: contrast_preset = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
            begin
                owed_results.push_back(map_access(item));
            end
            replies_owed <= owed_results.size();
        end
    end

endmodule

[test/lcd_keypad_i2c_register_map_test.sv]
module lcd_keypad_i2c_register_map_test;

    localparam int DISPLAY_BYTES = 80;
    localparam int GLYPH_BYTES = 64;
    localparam int ICON_BYTES = 16;
    localparam int GLYPH_BASE = lkm_pkg::MAP_FIXED + DISPLAY_BYTES;
    localparam int ICON_BASE = GLYPH_BASE + GLYPH_BYTES;
    localparam int MAP_END = ICON_BASE + ICON_BYTES;
    localparam int REQUEST_TARGET = 1950;
    localparam int PHASES = 6;
    localparam int WATCHDOG_LIMIT = 200;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    lkm_pkg::item_t   item = '0;
    logic             done;
    lkm_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = '0;
    logic [5:0]       cfg_data = '0;

    int         mismatches;
    int         replies_owed;
    int         requests_sent = 0;
    int         quiet_cycles = 0;
    bit         steady = 1'b0;
    logic [7:0] pointer_guess = '0;

    always #5 clk = ~clk;

    lcd_keypad_i2c_register_map #(
        .DISPLAY_BYTES(DISPLAY_BYTES),
        .GLYPH_BYTES(GLYPH_BYTES),
        .ICON_BYTES(ICON_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lkm_map_checker #(
        .DISPLAY_BYTES(DISPLAY_BYTES),
        .GLYPH_BYTES(GLYPH_BYTES),
        .ICON_BYTES(ICON_BYTES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .replies_owed(replies_owed)
    );

    // Any accepted request, result or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("lcd_keypad_i2c_register_map verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input lkm_pkg::kind_t kind, input logic [7:0] data,
                                input logic [7:0] key_code);
        int             gap;
        lkm_pkg::item_t req;
        gap = steady ? 0 : int'($urandom_range(0, 8));
        req.kind = kind;
        req.data = data;
        req.key_code = key_code;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= req;
        do @(posedge clk); while (busy);
        requests_sent++;
    endtask

    task automatic write_register(input logic [1:0] index, input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Settings change only once every request has had its result.
    task automatic write_settings(input logic [5:0] contrast_cap, input logic [1:0] row_cap,
                                  input logic [5:0] column_cap,
                                  input logic [5:0] contrast_preset);
        start <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
        repeat (2) @(posedge clk);
        write_register(lkm_pkg::CFG_CONTRAST_LIMIT, contrast_cap);
        write_register(lkm_pkg::CFG_ROW_LIMIT, {4'd0, row_cap});
        write_register(lkm_pkg::CFG_COLUMN_LIMIT, column_cap);
        write_register(lkm_pkg::CFG_CONTRAST_DEFAULT, contrast_preset);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pointer();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 8'($urandom_range(0, lkm_pkg::MAP_FIXED - 1));
        if (r < 50)
            return 8'($urandom_range(lkm_pkg::MAP_FIXED, GLYPH_BASE - 1));
        if (r < 65)
            return 8'($urandom_range(GLYPH_BASE, ICON_BASE - 1));
        if (r < 92)
            return 8'($urandom_range(ICON_BASE - 8, MAP_END - 1));
        return 8'($urandom_range(MAP_END, 255));
    endfunction

    // A few transfers are broken by a stray bus event before the pointer byte.
    task automatic point_at(input logic [7:0] p);
        send_request(lkm_pkg::KIND_WR_ADDR, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0)
            send_request(lkm_pkg::KIND_BUS_MISC, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        send_request(lkm_pkg::KIND_WR_DATA, p, 8'($urandom_range(0, 255)));
        pointer_guess = p;
    endtask

    task automatic run_sequence();
        int         r;
        int         count;
        logic [7:0] v;
        if ($urandom_range(0, 15) == 0)
            steady = !steady;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            point_at(pick_pointer());
            count = $urandom_range(1, 6);
            repeat (count)
            begin
                r = $urandom_range(0, 9);
                // Values mostly sit near the limit of the field being written.
                if (r == 0)
                    v = 8'($urandom_range(0, 255));
                else if (r < 3)
                    v = 8'($urandom_range(0, 3));
                else if (pointer_guess == lkm_pkg::ADDR_POWER
                         || pointer_guess == lkm_pkg::ADDR_CURSOR)
                    v = 8'($urandom_range(0, 4));
                else if (pointer_guess == lkm_pkg::ADDR_CONTRAST)
                    v = 8'($urandom_range(0, 64));
                else if (pointer_guess == lkm_pkg::ADDR_ROW)
                    v = 8'($urandom_range(0, 4));
                else if (pointer_guess == lkm_pkg::ADDR_COLUMN)
                    v = 8'($urandom_range(0, 40));
                else if (int'(pointer_guess) >= GLYPH_BASE)
                    v = 8'($urandom_range(0, int'(lkm_pkg::PIXEL_MAX) + 1));
                else
                    v = 8'($urandom_range(0, 255));
                send_request(lkm_pkg::KIND_WR_DATA, v, 8'($urandom_range(0, 255)));
                pointer_guess = pointer_guess + 8'd1;
            end
        end
        else if (r < 60)
        begin
            point_at(pick_pointer());
            send_request(lkm_pkg::KIND_RD_ADDR, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            count = $urandom_range(0, 4);
            repeat (count)
                send_request(lkm_pkg::KIND_RD_ACK, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            send_request(lkm_pkg::KIND_RD_NACK, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        end
        else if (r < 75)
        begin
            send_request(lkm_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                         $urandom_range(0, 1) ? lkm_pkg::NO_KEY : 8'($urandom_range(0, 255)));
        end
        else if (r < 85)
        begin
            send_request(lkm_pkg::KIND_FETCH, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        end
        else
        begin
            send_request(lkm_pkg::kind_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset settings.
        send_request(lkm_pkg::KIND_RD_ADDR, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_RD_ACK, 8'hFF, 8'hFF);
        send_request(lkm_pkg::KIND_RD_NACK, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_TICK, 8'hFF, 8'h00);
        send_request(lkm_pkg::KIND_TICK, 8'h00, lkm_pkg::NO_KEY);
        send_request(lkm_pkg::KIND_WR_ADDR, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::ADDR_STATUS, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'h5A, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'hFF, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::CODE_MAX + 8'd1, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd2, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd63, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::CODE_MAX + 8'd1, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::CODE_MAX, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd2, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd1, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd16, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'd15, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'hFF, 8'h00);
        send_request(lkm_pkg::KIND_FETCH, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_FETCH, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_WR_ADDR, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'(MAP_END - 1), 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::PIXEL_MAX + 8'd1, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, lkm_pkg::PIXEL_MAX, 8'h00);
        send_request(lkm_pkg::KIND_RD_ACK, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_WR_ADDR, 8'h00, 8'h00);
        send_request(lkm_pkg::KIND_WR_DATA, 8'hFF, 8'h00);
        send_request(lkm_pkg::KIND_BUS_MISC, 8'h00, 8'h00);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: write_settings(6'd0, 2'd0, 6'd0, 6'd0);
                1: write_settings(6'd63, 2'd3, 6'd39, 6'd63);
                2: write_settings(lkm_pkg::CONTRAST_LIMIT_RST, lkm_pkg::ROW_LIMIT_RST,
                                  lkm_pkg::COLUMN_LIMIT_RST, lkm_pkg::CONTRAST_DEFAULT_RST);
                default: write_settings(6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                                        6'($urandom_range(0, 39)), 6'($urandom_range(0, 63)));
            endcase
            while (requests_sent < REQUEST_TARGET * (phase + 1) / PHASES)
                run_sequence();
        end

        start <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("lcd_keypad_i2c_register_map verification clean");
        else
            $display("lcd_keypad_i2c_register_map verification failed");
        $finish;
    end

endmodule

[sim.f]
design/lkm_pkg.sv
design/lkm_store.sv
design/lcd_keypad_i2c_register_map.sv
test/lkm_map_checker.sv
test/lcd_keypad_i2c_register_map_test.sv
